// ===== src/eamt_pkg.sv =====
// Shared types, codes and mask helpers for the explicit address mapping table.
package eamt_pkg;

    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_T64    = 3'd2;
    localparam logic [2:0] MODE_T46    = 3'd3;
    localparam logic [2:0] MODE_HAS6   = 3'd4;
    localparam logic [2:0] MODE_HAS4   = 3'd5;
    localparam logic [2:0] MODE_FLUSH  = 3'd6;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_EXISTS   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic [7:0] V6_BITS = 8'd128;
    localparam logic [5:0] V4_BITS = 6'd32;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] addr6_high;
        logic [63:0] addr6_low;
        logic [7:0]  len6;
        logic [31:0] addr4;
        logic [5:0]  len4;
        logic        force_add;
        logic        use6;
        logic        use4;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic        hit;
        logic [4:0]  entry_count;
    } t_out;

    typedef struct packed {
        t_in  item;
        logic bad;
    } t_qent;

    typedef struct packed {
        logic [127:0] p6;
        logic [7:0]   l6;
        logic [31:0]  p4;
        logic [5:0]   l4;
    } t_ent;

    function automatic logic [127:0] mask6(input logic [7:0] len);
        mask6 = ~({128{1'b1}} >> len);
    endfunction

    function automatic logic [31:0] mask4(input logic [5:0] len);
        mask4 = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

// ===== src/eamt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module eamt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

// ===== src/eamt_front.sv =====
// Front end: accept and pre-validate beats, hold them in a two-entry queue.
module eamt_front import eamt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_in   i_item,
    output logic  o_q_valid,
    input  logic  i_q_ready,
    output t_qent o_q
);
    t_qent      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       bad, push, pop;
    logic       add_bad, rm_bad;

    always_comb begin
        add_bad = (i_item.len6 > V6_BITS) || (i_item.len4 > V4_BITS)
               || (({i_item.addr6_high, i_item.addr6_low} & ~mask6(i_item.len6)) != '0)
               || ((i_item.addr4 & ~mask4(i_item.len4)) != '0)
               || ({1'b0, i_item.len6} > 9'd96 + {3'b0, i_item.len4});
        rm_bad  = (!i_item.use6 && !i_item.use4)
               || (i_item.use6 && i_item.len6 > V6_BITS)
               || (i_item.use4 && i_item.len4 > V4_BITS);
        unique case (i_item.mode)
            MODE_ADD:    bad = add_bad;
            MODE_REMOVE: bad = rm_bad;
            MODE_T64, MODE_T46, MODE_HAS6, MODE_HAS4, MODE_FLUSH: bad = 1'b0;
            default:     bad = 1'b1;
        endcase
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q       = r_mem[r_rp];
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{item: i_item, bad: bad};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== src/eamt_back.sv =====
// Back end: scan the table, update entries and produce one result per beat.
module eamt_back import eamt_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    output logic  o_q_ready,
    input  t_qent i_q,
    output logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0] o_rd_addr,
    input  t_ent  i_rd_data,
    output logic  o_wr_en,
    output logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0] o_wr_addr,
    output t_ent  o_wr_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_out  o_res
);
    localparam int IW = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LAST, S_FIN} t_state;

    t_state                   r_state;
    t_in                      r_item;
    logic                     r_bad;
    logic [IW-1:0]            r_addr, r_rd_idx;
    logic                     r_rd_act;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [CW-1:0]            r_total, n_total;
    logic                     r_b6_f, r_b4_f, r_x6_f, r_x4_f, r_fr_f;
    logic [7:0]               r_b6_len;
    logic [5:0]               r_b4_len;
    logic [IW-1:0]            r_x6_idx, r_x4_idx, r_fr_idx;
    t_ent                     r_bdata;
    logic                     r_ovalid;
    t_out                     r_out;

    logic         v, m6, m4, x6, x4, up6, up4, out_free;
    logic [127:0] a6, sh, v6;
    logic [7:0]   rsh;
    logic         do_wr, do_rm;
    logic [IW-1:0] rm_idx;
    t_out         res;

    assign a6  = {r_item.addr6_high, r_item.addr6_low};
    assign v   = r_valid[r_rd_idx];
    assign m6  = v && (((a6 ^ i_rd_data.p6) & mask6(i_rd_data.l6)) == '0);
    assign m4  = v && (((r_item.addr4 ^ i_rd_data.p4) & mask4(i_rd_data.l4)) == '0);
    assign x6  = v && (i_rd_data.l6 == r_item.len6)
               && (((a6 ^ i_rd_data.p6) & mask6(r_item.len6)) == '0);
    assign x4  = v && (i_rd_data.l4 == r_item.len4)
               && (((r_item.addr4 ^ i_rd_data.p4) & mask4(r_item.len4)) == '0);
    assign up6 = r_rd_act && m6 && (!r_b6_f || i_rd_data.l6 > r_b6_len);
    assign up4 = r_rd_act && m4 && (!r_b4_f || i_rd_data.l4 > r_b4_len);

    assign out_free  = !r_ovalid || i_ready;
    assign o_q_ready = (r_state == S_IDLE);
    assign o_rd_addr = r_addr;
    assign o_wr_en   = (r_state == S_FIN) && out_free && do_wr;
    assign o_wr_addr = r_fr_idx;
    assign o_wr_data = '{p6: a6, l6: r_item.len6, p4: r_item.addr4, l4: r_item.len4};
    assign o_valid   = r_ovalid;
    assign o_res     = r_out;

    always_comb begin
        res    = '0;
        do_wr  = 1'b0;
        do_rm  = 1'b0;
        rm_idx = r_item.use6 ? r_x6_idx : r_x4_idx;
        sh     = a6 << r_bdata.l6;
        rsh    = 8'd96 + {2'b0, r_bdata.l4} - r_bdata.l6;
        v6     = (r_bdata.p6 & mask6(r_bdata.l6))
               | ({96'b0, r_item.addr4 & ~mask4(r_bdata.l4)} << rsh);
        unique case (r_item.mode)
            MODE_ADD: begin
                if (r_bad) res.status = ST_INVALID;
                else if (!r_item.force_add && (r_b6_f || r_b4_f)) res.status = ST_EXISTS;
                else if (r_x6_f || r_x4_f) res.status = ST_EXISTS;
                else if (!r_fr_f) res.status = ST_FULL;
                else do_wr = 1'b1;
            end
            MODE_REMOVE: begin
                if (r_bad) res.status = ST_INVALID;
                else if (r_item.use6 && !r_x6_f) res.status = ST_NOTFOUND;
                else if (r_item.use4 && !r_x4_f) res.status = ST_NOTFOUND;
                else if (r_item.use6 && r_item.use4 && r_x6_idx != r_x4_idx)
                    res.status = ST_NOTFOUND;
                else do_rm = 1'b1;
            end
            MODE_T64: begin
                if (!r_b6_f) res.status = ST_NOTFOUND;
                else res.out_low = {32'b0, (r_bdata.p4 & mask4(r_bdata.l4))
                                         | (sh[127:96] >> r_bdata.l4)};
            end
            MODE_T46: begin
                if (!r_b4_f) res.status = ST_NOTFOUND;
                else begin
                    res.out_high = v6[127:64];
                    res.out_low  = v6[63:0];
                end
            end
            MODE_HAS6:  res.hit = r_b6_f;
            MODE_HAS4:  res.hit = r_b4_f;
            MODE_FLUSH: res.status = ST_OK;
            default:    res.status = ST_INVALID;
        endcase
        if (r_item.mode == MODE_FLUSH) n_total = '0;
        else if (do_wr) n_total = r_total + 1'b1;
        else if (do_rm && r_total != '0) n_total = r_total - 1'b1;
        else n_total = r_total;
        res.entry_count = 5'(n_total);
    end

    always_ff @(posedge i_clk) begin
        r_rd_act <= (r_state == S_SCAN);
        r_rd_idx <= r_addr;
        if (r_state == S_IDLE && i_q_valid) begin
            r_item <= i_q.item;
            r_bad  <= i_q.bad;
        end
        if (up6 && r_item.mode == MODE_T64) r_bdata <= i_rd_data;
        if (up4 && r_item.mode == MODE_T46) r_bdata <= i_rd_data;
        if (r_state == S_FIN && out_free) r_out <= res;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
            r_addr   <= '0;
            r_b6_f   <= 1'b0;
            r_b4_f   <= 1'b0;
            r_x6_f   <= 1'b0;
            r_x4_f   <= 1'b0;
            r_fr_f   <= 1'b0;
        end else begin
            if (r_state == S_FIN && out_free) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (up6) begin
                r_b6_f   <= 1'b1;
                r_b6_len <= i_rd_data.l6;
            end
            if (up4) begin
                r_b4_f   <= 1'b1;
                r_b4_len <= i_rd_data.l4;
            end
            if (r_rd_act && x6 && !r_x6_f) begin
                r_x6_f   <= 1'b1;
                r_x6_idx <= r_rd_idx;
            end
            if (r_rd_act && x4 && !r_x4_f) begin
                r_x4_f   <= 1'b1;
                r_x4_idx <= r_rd_idx;
            end
            if (r_rd_act && !v && !r_fr_f) begin
                r_fr_f   <= 1'b1;
                r_fr_idx <= r_rd_idx;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_addr <= '0;
                    r_b6_f <= 1'b0;
                    r_b4_f <= 1'b0;
                    r_x6_f <= 1'b0;
                    r_x4_f <= 1'b0;
                    r_fr_f <= 1'b0;
                    if (i_q_valid) begin
                        if (i_q.bad || i_q.item.mode == MODE_FLUSH) r_state <= S_FIN;
                        else r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_addr == LAST) r_state <= S_LAST;
                    else r_addr <= r_addr + 1'b1;
                end
                S_LAST: r_state <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        r_total  <= n_total;
                        if (r_item.mode == MODE_FLUSH) r_valid <= '0;
                        if (do_wr) r_valid[r_fr_idx] <= 1'b1;
                        if (do_rm) r_valid[rm_idx] <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/explicit_address_mapping_table.sv =====
// Top level of the explicit address mapping table.
// Input channel i_valid/o_ready carries one operation beat (t_in): add, remove,
// translate 6to4 or 4to6, contains6, contains4 or flush. Output channel
// o_valid/i_ready returns exactly one result beat (t_out) per operation, in order.
// A two-entry queue takes beats while the back end works on an earlier one.
// Table lookups read the entry memory one entry per cycle, scanning every entry
// before the result is registered; flush and rejected beats skip the scan. The
// back end takes one operation at a time from the queue and takes the next only
// once the result of the last one is registered.
// Reset (i_rst_n low, synchronous) empties the table, the queue and the output
// register. When the receiver stalls, the result holds in the output register,
// the back end waits, and the queue fills and then drops o_ready.
module explicit_address_mapping_table import eamt_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_item,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_res
);
    localparam int IW = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;

    logic          q_valid, q_ready, wr_en;
    t_qent         q;
    logic [IW-1:0] rd_addr, wr_addr;
    t_ent          rd_data, wr_data;
    logic [$bits(t_ent)-1:0] rd_raw;

    assign rd_data = t_ent'(rd_raw);

    eamt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (i_item),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q       (q)
    );

    eamt_ram #(.WIDTH($bits(t_ent)), .DEPTH(TABLE_ENTRIES)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    eamt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q       (q),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (o_res)
    );
endmodule

// ===== src/eamt_check.sv =====
// Port-level checker for the explicit address mapping table, with its bind.
module eamt_check import eamt_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input t_in  i_item,
    input logic o_valid,
    input logic i_ready,
    input t_out o_res
);
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res))
        else $error("stalled result changed");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.entry_count <= 5'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.status != ST_OK |->
            o_res.out_high == '0 && o_res.out_low == '0 && !o_res.hit)
        else $error("failed result carries data");
endmodule

bind explicit_address_mapping_table eamt_check #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_check (.*);

// ===== verif/tb_explicit_address_mapping_table.sv =====
// Self-checking testbench for the explicit address mapping table.
module tb_explicit_address_mapping_table;
    import eamt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int RAND_ITEMS = 1530;
    localparam int IN_W = $bits(t_in);
    localparam logic [2:0] MODE_NONE = 3'd7;
    localparam logic [127:0] NET6 = 128'h2001_0db8_0000_0000_0000_0000_0000_0000;
    localparam logic [127:0] NET6B = 128'h2001_0db8_0001_0000_0000_0000_0000_0000;
    localparam logic [31:0] NET4 = 32'hC000_0200;

    typedef struct {
        t_in  item;
        bit   typed;
        t_out res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_item = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_res;

    bit           map_valid[SLOTS];
    logic [127:0] map_p6[SLOTS];
    logic [7:0]   map_l6[SLOTS];
    logic [31:0]  map_p4[SLOTS];
    logic [5:0]   map_l4[SLOTS];
    int           map_total = 0;

    t_row stim_rows[$];
    t_out pending_res[$];
    t_row cur;
    bit   running = 0;
    int   items_sent = 0;
    int   items_taken = 0;
    int   total_items;
    int   errors = 0;
    int   n_added = 0;
    int   n_full = 0;
    int   n_xlate = 0;
    int   n_removed = 0;

    explicit_address_mapping_table uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .o_valid(o_valid), .i_ready(i_ready), .o_res(o_res)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [127:0] net_mask6(int len);
        if (len <= 0) return '0;
        return {128{1'b1}} << (128 - len);
    endfunction

    function automatic logic [31:0] net_mask4(int len);
        if (len <= 0) return '0;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function automatic int longest6(logic [127:0] a);
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (map_valid[i] && ((a ^ map_p6[i]) & net_mask6(map_l6[i])) == '0 &&
                (best < 0 || map_l6[i] > map_l6[best]))
                best = i;
        return best;
    endfunction

    function automatic int longest4(logic [31:0] a);
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (map_valid[i] && ((a ^ map_p4[i]) & net_mask4(map_l4[i])) == '0 &&
                (best < 0 || map_l4[i] > map_l4[best]))
                best = i;
        return best;
    endfunction

    function automatic int exact6(logic [127:0] a, int len);
        for (int i = 0; i < SLOTS; i++)
            if (map_valid[i] && map_l6[i] == len && ((a ^ map_p6[i]) & net_mask6(len)) == '0)
                return i;
        return -1;
    endfunction

    function automatic int exact4(logic [31:0] a, int len);
        for (int i = 0; i < SLOTS; i++)
            if (map_valid[i] && map_l4[i] == len && ((a ^ map_p4[i]) & net_mask4(len)) == '0)
                return i;
        return -1;
    endfunction

    function automatic logic [2:0] insert_pair(t_in it);
        logic [127:0] p6;
        int l6, l4;
        p6 = {it.addr6_high, it.addr6_low};
        l6 = it.len6;
        l4 = it.len4;
        if (l6 > 128 || l4 > 32) return ST_INVALID;
        if ((p6 & ~net_mask6(l6)) != '0 || (it.addr4 & ~net_mask4(l4)) != '0)
            return ST_INVALID;
        if (32 - l4 > 128 - l6) return ST_INVALID;
        if (!it.force_add && (longest6(p6) >= 0 || longest4(it.addr4) >= 0)) return ST_EXISTS;
        if (exact6(p6, l6) >= 0 || exact4(it.addr4, l4) >= 0) return ST_EXISTS;
        for (int i = 0; i < SLOTS; i++) begin
            if (!map_valid[i]) begin
                map_valid[i] = 1;
                map_p6[i] = p6;
                map_l6[i] = it.len6;
                map_p4[i] = it.addr4;
                map_l4[i] = it.len4;
                map_total++;
                n_added++;
                return ST_OK;
            end
        end
        n_full++;
        return ST_FULL;
    endfunction

    function automatic logic [2:0] drop_pair(t_in it);
        int i6, i4;
        i6 = -1;
        i4 = -1;
        if (!it.use6 && !it.use4) return ST_INVALID;
        if ((it.use6 && it.len6 > 128) || (it.use4 && it.len4 > 32)) return ST_INVALID;
        if (it.use6) begin
            i6 = exact6({it.addr6_high, it.addr6_low}, it.len6);
            if (i6 < 0) return ST_NOTFOUND;
        end
        if (it.use4) begin
            i4 = exact4(it.addr4, it.len4);
            if (i4 < 0) return ST_NOTFOUND;
        end
        if (it.use6 && it.use4 && i6 != i4) return ST_NOTFOUND;
        map_valid[it.use6 ? i6 : i4] = 0;
        if (map_total > 0) map_total--;
        n_removed++;
        return ST_OK;
    endfunction

    function automatic t_out apply_op(t_in it);
        t_out r;
        logic [127:0] a6, v6, suf6;
        logic [127:0] sh;
        int e, n, p6;
        r = '0;
        a6 = {it.addr6_high, it.addr6_low};
        case (it.mode)
            MODE_ADD: r.status = insert_pair(it);
            MODE_REMOVE: r.status = drop_pair(it);
            MODE_T64: begin
                e = longest6(a6);
                if (e < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    n = 32 - map_l4[e];
                    sh = (n > 0) ? ((a6 << map_l6[e]) >> (128 - n)) : '0;
                    r.out_low = {32'h0, (map_p4[e] & net_mask4(map_l4[e])) | sh[31:0]};
                    n_xlate++;
                end
            end
            MODE_T46: begin
                e = longest4(it.addr4);
                if (e < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    p6 = map_l6[e];
                    n = 32 - map_l4[e];
                    v6 = map_p6[e] & net_mask6(p6);
                    if (n > 0) begin
                        suf6 = {96'h0, it.addr4} & ~({128{1'b1}} << n);
                        v6 = v6 | (suf6 << (128 - (p6 + n)));
                    end
                    {r.out_high, r.out_low} = v6;
                    n_xlate++;
                end
            end
            MODE_HAS6: r.hit = longest6(a6) >= 0;
            MODE_HAS4: r.hit = longest4(it.addr4) >= 0;
            MODE_FLUSH: begin
                for (int i = 0; i < SLOTS; i++) map_valid[i] = 0;
                map_total = 0;
            end
            default: r.status = ST_INVALID;
        endcase
        r.entry_count = map_total[4:0];
        return r;
    endfunction

    function automatic t_in op(logic [2:0] m, logic [127:0] a6, logic [7:0] l6,
                               logic [31:0] a4, logic [5:0] l4, bit f, bit u6, bit u4);
        t_in it;
        it.mode = m;
        {it.addr6_high, it.addr6_low} = a6;
        it.len6 = l6;
        it.addr4 = a4;
        it.len4 = l4;
        it.force_add = f;
        it.use6 = u6;
        it.use4 = u4;
        return it;
    endfunction

    function automatic t_out res(logic [2:0] st, bit h, int cnt);
        t_out r;
        r = '0;
        r.status = st;
        r.hit = h;
        r.entry_count = cnt[4:0];
        return r;
    endfunction

    task automatic row(t_in it, bit typed = 0, t_out r = '0);
        t_row w;
        w.item = it;
        w.typed = typed;
        w.res = r;
        stim_rows.push_back(w);
    endtask

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic t_in random_op();
        t_in it;
        int k, s, l4, l6;
        logic [127:0] m6;
        it = IN_W'({$urandom, rand128(), $urandom, $urandom, $urandom});
        k = $urandom_range(0, 99);
        s = $urandom_range(0, SLOTS - 1);
        if (k < 4) begin
            it.mode = 3'($urandom_range(0, 7));
            return it;
        end
        if (k < 38) begin
            l4 = $urandom_range(0, 32);
            l6 = $urandom_range(0, 96 + l4);
            m6 = net_mask6(l6);
            it.mode = MODE_ADD;
            {it.addr6_high, it.addr6_low} = rand128() & m6;
            it.len6 = 8'(l6);
            it.addr4 = $urandom & net_mask4(l4);
            it.len4 = 6'(l4);
            it.force_add = $urandom_range(0, 9) < 7;
            if (map_valid[s] && $urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1)) begin
                    {it.addr6_high, it.addr6_low} = map_p6[s];
                    it.len6 = map_l6[s];
                end else begin
                    it.addr4 = map_p4[s];
                    it.len4 = map_l4[s];
                end
            end
        end else if (k < 52) begin
            it.mode = MODE_REMOVE;
            if (map_valid[s] && $urandom_range(0, 4) != 0) begin
                {it.addr6_high, it.addr6_low} = map_p6[s];
                it.len6 = map_l6[s];
                it.addr4 = map_p4[$urandom_range(0, 9) == 0 ? $urandom_range(0, SLOTS - 1) : s];
                it.len4 = map_l4[s];
                it.use6 = $urandom_range(0, 2) != 0;
                it.use4 = !it.use6 || $urandom_range(0, 1);
            end
        end else if (k < 98) begin
            it.mode = k < 67 ? MODE_T64 : k < 82 ? MODE_T46 : k < 90 ? MODE_HAS6 : MODE_HAS4;
            if (map_valid[s] && $urandom_range(0, 4) != 0) begin
                m6 = net_mask6(map_l6[s]);
                {it.addr6_high, it.addr6_low} = map_p6[s] | (rand128() & ~m6);
                it.addr4 = map_p4[s] | ($urandom & ~net_mask4(map_l4[s]));
            end
        end else begin
            it.mode = MODE_FLUSH;
        end
        return it;
    endfunction

    task automatic check_res(t_out got);
        t_out want;
        if (pending_res.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat %h", $time, got);
            return;
        end
        want = pending_res.pop_front();
        if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.out_high !== want.out_high)
            $display("%0t: out_high expected %h actual %h", $time, want.out_high, got.out_high);
        if (got.out_low !== want.out_low)
            $display("%0t: out_low expected %h actual %h", $time, want.out_low, got.out_low);
        if (got.hit !== want.hit)
            $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
        if (got.entry_count !== want.entry_count)
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     want.entry_count, got.entry_count);
        if (got !== want) errors++;
    endtask

    function automatic int idle_phase();
        if (items_sent < stim_rows.size()) return 0;
        return ((items_sent - stim_rows.size()) / 200) % 4;
    endfunction

    always @(posedge i_clk) begin
        int ph;
        bit hold_tx, hold_rx;
        if (running) begin
            if (i_valid && o_ready) begin
                items_taken++;
                if (cur.typed) begin
                    pending_res.push_back(cur.res);
                    void'(apply_op(cur.item));
                end else begin
                    pending_res.push_back(apply_op(cur.item));
                end
            end
            if (o_valid && i_ready) check_res(o_res);
            ph = idle_phase();
            hold_tx = (ph == 1 && $urandom_range(0, 99) < 55) ||
                      (ph == 3 && $urandom_range(0, 99) < 27);
            hold_rx = (ph == 2 && $urandom_range(0, 99) < 55) ||
                      (ph == 3 && $urandom_range(0, 99) < 27);
            if (!i_valid || o_ready) begin
                if (items_sent < total_items && !hold_tx) begin
                    if (items_sent < stim_rows.size()) begin
                        cur = stim_rows[items_sent];
                    end else begin
                        cur.item = random_op();
                        cur.typed = 0;
                    end
                    i_item <= cur.item;
                    i_valid <= 1'b1;
                    items_sent++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= !hold_rx;
        end
    end

    initial begin
        row(op(MODE_T64, '1, 8'd0, 32'h0, 6'd0, 0, 0, 0), 1, res(ST_NOTFOUND, 0, 0));
        row(op(MODE_HAS6, '0, 8'd0, 32'h0, 6'd0, 0, 0, 0), 1, res(ST_OK, 0, 0));
        row(op(MODE_NONE, '1, 8'hFF, '1, 6'h3F, 1, 1, 1), 1, res(ST_INVALID, 0, 0));
        row(op(MODE_ADD, '0, 8'hFF, 32'h0, 6'd0, 0, 0, 0), 1, res(ST_INVALID, 0, 0));
        row(op(MODE_ADD, '0, 8'd0, 32'h0, 6'h3F, 0, 0, 0), 1, res(ST_INVALID, 0, 0));
        row(op(MODE_ADD, NET6 | 128'h1, 8'd96, NET4, 6'd24, 0, 0, 0), 1,
            res(ST_INVALID, 0, 0));
        row(op(MODE_ADD, NET6, 8'd120, 32'h0, 6'd0, 1, 0, 0), 1, res(ST_INVALID, 0, 0));
        row(op(MODE_ADD, NET6, 8'd96, NET4, 6'd24, 0, 0, 0), 1, res(ST_OK, 0, 1));
        row(op(MODE_ADD, NET6, 8'd96, NET4, 6'd24, 0, 0, 0), 1, res(ST_EXISTS, 0, 1));
        row(op(MODE_ADD, NET6B, 8'd96, NET4, 6'd24, 1, 0, 0), 1, res(ST_EXISTS, 0, 1));
        row(op(MODE_T64, NET6 | 128'hAB, 8'd0, 32'h0, 6'd0, 0, 0, 0));
        row(op(MODE_T46, '0, 8'd0, 32'hC000_02CD, 6'd0, 0, 0, 0));
        row(op(MODE_ADD, '1, 8'd128, '1, 6'd32, 0, 0, 0));
        row(op(MODE_ADD, '0, 8'd0, 32'h0, 6'd0, 1, 0, 0));
        row(op(MODE_T64, '1, 8'd0, 32'h0, 6'd0, 0, 0, 0));
        row(op(MODE_T46, '0, 8'd0, 32'h1234_5678, 6'd0, 0, 0, 0));
        row(op(MODE_HAS4, '0, 8'd0, 32'h0A00_0001, 6'd0, 0, 0, 0));
        row(op(MODE_REMOVE, NET6, 8'd96, NET4, 6'd24, 0, 0, 0));
        row(op(MODE_REMOVE, NET6, 8'hFF, NET4, 6'd24, 0, 1, 0));
        row(op(MODE_REMOVE, NET6, 8'd96, '1, 6'd32, 0, 1, 1));
        row(op(MODE_REMOVE, '0, 8'd0, NET4, 6'd24, 0, 0, 1));
        row(op(MODE_HAS6, NET6, 8'd0, 32'h0, 6'd0, 0, 0, 0));
        row(op(MODE_FLUSH, '0, 8'd0, 32'h0, 6'd0, 0, 0, 0), 1, res(ST_OK, 0, 0));
        row(op(MODE_T46, '0, 8'd0, '1, 6'd0, 0, 0, 0), 1, res(ST_NOTFOUND, 0, 0));
        total_items = stim_rows.size() + RAND_ITEMS;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        running <= 1'b1;
        wait (items_taken == total_items && pending_res.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("Ran %0d operations: %0d pairs added, %0d removed, %0d table-full rejects,",
                 items_taken, n_added, n_removed, n_full);
        $display("%0d translations hit, under four sender/receiver idling patterns.", n_xlate);
        if (errors == 0 && pending_res.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("%0t: timeout with %0d results outstanding", $time, pending_res.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
